// ===== rtl/core/vcfc_pkg.sv =====
// vcfc_pkg: shared types, constants and the face test of the voxel column face culler
// used by vcfc_height_mem, vcfc_scan_ctrl and voxel_column_face_cull
package vcfc_pkg;

  localparam int CoordW   = 4;
  localparam int HeightW  = 5;
  localparam int LevelW   = 4;
  localparam int AddrW    = 2 * CoordW;
  localparam int Depth    = 1 << AddrW;
  localparam int MaskW    = 6;

  localparam logic [HeightW-1:0] MaxHeight = HeightW'(16);
  localparam logic [LevelW-1:0]  TopLevel  = LevelW'(15);
  localparam logic [CoordW-1:0]  CoordMax  = CoordW'(15);
  localparam logic [CoordW-1:0]  CoordMin  = CoordW'(0);

  // item kinds
  localparam logic KindLoad = 1'b0;
  localparam logic KindScan = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } state_t;

  // request from the scan control to the height memory
  typedef struct packed {
    logic               we;
    logic [AddrW-1:0]   waddr;
    logic [HeightW-1:0] wdata;
    logic [AddrW-1:0]   raddr;
  } mem_req_t;

  // exposed faces of one solid voxel at level y
  function automatic logic [MaskW-1:0] face_mask_f(
    input logic [LevelW-1:0]  y,
    input logic [HeightW-1:0] h_own,
    input logic [HeightW-1:0] h_zp,
    input logic [HeightW-1:0] h_zm,
    input logic [HeightW-1:0] h_xm,
    input logic [HeightW-1:0] h_xp,
    input logic               z_hi_edge,
    input logic               z_lo_edge,
    input logic               x_lo_edge,
    input logic               x_hi_edge
  );
    logic [HeightW-1:0] y_ext;
    logic [HeightW-1:0] y_up;
    logic [MaskW-1:0]   m;
    y_ext = {1'b0, y};
    y_up  = y_ext + HeightW'(1);
    m[0] = z_hi_edge || !(y_ext < h_zp);
    m[1] = z_lo_edge || !(y_ext < h_zm);
    m[2] = (y == TopLevel) || !(y_up < h_own);
    m[3] = (y == LevelW'(0));
    m[4] = x_lo_edge || !(y_ext < h_xm);
    m[5] = x_hi_edge || !(y_ext < h_xp);
    return m;
  endfunction

endpackage

// ===== rtl/core/vcfc_height_mem.sv =====
// vcfc_height_mem: column height memory, one write and one registered read port
// entries not written since reset read as zero through per-entry valid bits; uses vcfc_pkg
module vcfc_height_mem
  import vcfc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  mem_req_t           req,
  output logic [HeightW-1:0] rdata
);

  logic [HeightW-1:0] mem [Depth];
  logic [Depth-1:0]   valid;
  logic [HeightW-1:0] rd_data;
  logic               rd_valid;

  // storage array
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data <= mem[req.raddr];
  end

  // written marks, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (req.we) begin
        valid[req.waddr] <= 1'b1;
      end
      rd_valid <= valid[req.raddr];
    end
  end

  assign rdata = rd_valid ? rd_data : '0;

endmodule

// ===== rtl/core/vcfc_scan_ctrl.sv =====
// vcfc_scan_ctrl: load and scan sequencer, gathers five heights then emits one beat per level
// depends on vcfc_pkg and drives the vcfc_height_mem port
module vcfc_scan_ctrl
  import vcfc_pkg::*;
#(
  parameter int CHUNK_SIDE = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               kind,
  input  logic [CoordW-1:0]  column_x,
  input  logic [CoordW-1:0]  column_z,
  input  logic [HeightW-1:0] height,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [CoordW-1:0]  out_x,
  output logic [CoordW-1:0]  out_z,
  output logic [LevelW-1:0]  level,
  output logic [MaskW-1:0]   face_mask,
  output logic               last,
  output mem_req_t           mem_req,
  input  logic [HeightW-1:0] mem_rdata
);

  localparam logic [6:0] Side = 7'(CHUNK_SIDE);
  localparam logic [6:0] Edge = 7'(CHUNK_SIDE - 1);

  state_t             state, state_next;
  logic [2:0]         step, step_next;
  logic [LevelW-1:0]  y, y_next;
  logic [CoordW-1:0]  cur_x, cur_z;
  logic [HeightW-1:0] h_own, h_zp, h_zm, h_xm, h_xp;
  logic               accept, in_chunk, out_load;
  logic [HeightW-1:0] load_h;
  logic               x_lo_edge, x_hi_edge, z_lo_edge, z_hi_edge;

  assign in_chunk = ({3'b0, column_x} < Side) && ({3'b0, column_z} < Side);
  assign accept   = in_valid && (state == ST_IDLE);
  assign in_stall = (state != ST_IDLE);

  // height clamp for load
  always_comb begin
    if (height == '0) begin
      load_h = HeightW'(1);
    end else if (height > MaxHeight) begin
      load_h = MaxHeight;
    end else begin
      load_h = height;
    end
  end

  assign x_lo_edge = (cur_x == CoordMin);
  assign z_lo_edge = (cur_z == CoordMin);
  assign x_hi_edge = ({3'b0, cur_x} == Edge);
  assign z_hi_edge = ({3'b0, cur_z} == Edge);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state, memory request and output load
  always_comb begin
    state_next    = state;
    step_next     = step;
    y_next        = y;
    out_load      = 1'b0;
    mem_req.we    = 1'b0;
    mem_req.waddr = {column_x, column_z};
    mem_req.wdata = load_h;
    mem_req.raddr = {cur_x, cur_z};
    unique case (state)
      ST_IDLE: begin
        if (accept && in_chunk) begin
          if (kind == KindLoad) begin
            mem_req.we = 1'b1;
          end else begin
            state_next = ST_READ;
            step_next  = 3'd0;
          end
        end
      end
      ST_READ: begin
        unique case (step)
          3'd1:    mem_req.raddr = {cur_x, cur_z + CoordW'(1)};
          3'd2:    mem_req.raddr = {cur_x, cur_z - CoordW'(1)};
          3'd3:    mem_req.raddr = {cur_x - CoordW'(1), cur_z};
          3'd4:    mem_req.raddr = {cur_x + CoordW'(1), cur_z};
          default: mem_req.raddr = {cur_x, cur_z};
        endcase
        step_next = step + 3'd1;
        if (step == 3'd5) begin
          state_next = ST_EMIT;
          y_next     = '0;
        end
      end
      ST_EMIT: begin
        if ({1'b0, y} >= h_own) begin
          state_next = ST_IDLE;
        end else if (!out_valid || !out_stall) begin
          out_load = 1'b1;
          if (({1'b0, y} + HeightW'(1)) == h_own) begin
            state_next = ST_IDLE;
          end else begin
            y_next = y + LevelW'(1);
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencing registers and captured heights
  always_ff @(posedge clk) begin
    step <= step_next;
    y    <= y_next;
    if (accept) begin
      cur_x <= column_x;
      cur_z <= column_z;
    end
    // read data arrives in the cycle after its address
    if (state == ST_READ) begin
      case (step)
        3'd1: h_own <= mem_rdata;
        3'd2: h_zp  <= (cur_z == CoordMax) ? '0 : mem_rdata;
        3'd3: h_zm  <= (cur_z == CoordMin) ? '0 : mem_rdata;
        3'd4: h_xm  <= (cur_x == CoordMin) ? '0 : mem_rdata;
        3'd5: h_xp  <= (cur_x == CoordMax) ? '0 : mem_rdata;
        default: ;
      endcase
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x     <= cur_x;
      out_z     <= cur_z;
      level     <= y;
      face_mask <= face_mask_f(y, h_own, h_zp, h_zm, h_xm, h_xp,
                               z_hi_edge, z_lo_edge, x_lo_edge, x_hi_edge);
      last      <= (({1'b0, y} + HeightW'(1)) == h_own);
    end
  end

endmodule

// ===== rtl/core/voxel_column_face_cull.sv =====
// voxel_column_face_cull: top level of the heightmap voxel face culler
// instantiates vcfc_height_mem and vcfc_scan_ctrl; uses vcfc_pkg
//
// Usage:
//   Input channel (in_valid / in_stall) carries one item per beat: kind 0 loads
//   a column height (zero stored as one, above sixteen stored as sixteen), kind 1
//   scans a column. Columns outside the chunk are taken and dropped.
//   Output channel (out_valid / out_stall) carries one beat per solid level of a
//   scanned column, bottom level first, with last set on the topmost level.
//   A scan reads five heights (own column and its four side neighbours) one per
//   cycle through the single memory read port, then emits one beat per cycle
//   while out_stall is low. One item is worked on at a time; in_stall is high
//   while a scan runs.
//   The output register holds a finished beat while the next item is taken.
//   When out_stall is high the current beat holds and the scan pauses.
//   Reset clears the control state and marks every column empty at once.
module voxel_column_face_cull
  import vcfc_pkg::*;
#(
  parameter int CHUNK_SIDE = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               kind,
  input  logic [CoordW-1:0]  column_x,
  input  logic [CoordW-1:0]  column_z,
  input  logic [HeightW-1:0] height,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [CoordW-1:0]  out_x,
  output logic [CoordW-1:0]  out_z,
  output logic [LevelW-1:0]  level,
  output logic [MaskW-1:0]   face_mask,
  output logic               last
);

  mem_req_t           mem_req;
  logic [HeightW-1:0] mem_rdata;

  // column height store
  vcfc_height_mem u_mem (
    .clk   (clk),
    .rst   (rst),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  // load and scan sequencing
  vcfc_scan_ctrl #(
    .CHUNK_SIDE (CHUNK_SIDE)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .column_x  (column_x),
    .column_z  (column_z),
    .height    (height),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_x     (out_x),
    .out_z     (out_z),
    .level     (level),
    .face_mask (face_mask),
    .last      (last),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

endmodule

// ===== bench/tb_voxel_column_face_cull.sv =====
`timescale 1ns / 1ps
// tb_voxel_column_face_cull: self-checking bench of the voxel column face culler
// drives load and scan beats, predicts exposed-face beats from a heightmap copy;
// depends on vcfc_pkg and voxel_column_face_cull
module tb_voxel_column_face_cull
  import vcfc_pkg::*;
();

  localparam int GRID         = 16;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 400;

  // face bit positions of face_mask
  localparam int FacePosZ = 0;
  localparam int FaceNegZ = 1;
  localparam int FacePosY = 2;
  localparam int FaceNegY = 3;
  localparam int FaceNegX = 4;
  localparam int FacePosX = 5;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] z;
    logic [LevelW-1:0] lvl;
    logic [MaskW-1:0]  mask;
    logic              top;
  } face_beat_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               kind = KindLoad;
  logic [CoordW-1:0]  column_x = '0;
  logic [CoordW-1:0]  column_z = '0;
  logic [HeightW-1:0] height = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [CoordW-1:0]  out_x;
  logic [CoordW-1:0]  out_z;
  logic [LevelW-1:0]  level;
  logic [MaskW-1:0]   face_mask;
  logic               last;

  logic [HeightW-1:0] model_heights [GRID*GRID];
  face_beat_t         pending_faces [$];
  int                 error_count = 0;
  int                 beat_count = 0;
  int                 send_idle_pct = 0;
  int                 recv_idle_pct = 0;
  logic               hold_off = 1'b0;
  event               hold_start;

  voxel_column_face_cull dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .column_x  (column_x),
    .column_z  (column_z),
    .height    (height),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_x     (out_x),
    .out_z     (out_z),
    .level     (level),
    .face_mask (face_mask),
    .last      (last)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // solidity of a voxel in the predicted heightmap, empty outside the grid
  function automatic logic is_solid(input int x, input int y, input int z);
    if (x < 0 || x >= GRID || z < 0 || z >= GRID) return 1'b0;
    return y < int'(model_heights[x*GRID + z]);
  endfunction

  // update the heightmap on a load, queue the face beats of a scan
  function automatic void predict_faces(input logic k, input logic [CoordW-1:0] cx,
                                        input logic [CoordW-1:0] cz,
                                        input logic [HeightW-1:0] h);
    int         top;
    int         x;
    int         z;
    face_beat_t b;
    x = int'(cx);
    z = int'(cz);
    if (k == KindLoad) begin
      if (h == '0) model_heights[x*GRID + z] = HeightW'(1);
      else if (h > MaxHeight) model_heights[x*GRID + z] = MaxHeight;
      else model_heights[x*GRID + z] = h;
      return;
    end
    top = int'(model_heights[x*GRID + z]);
    for (int y = 0; y < top; y++) begin
      b.x = cx;
      b.z = cz;
      b.lvl = LevelW'(y);
      b.mask[FacePosZ] = (cz == CoordMax) || !is_solid(x, y, z + 1);
      b.mask[FaceNegZ] = (cz == CoordMin) || !is_solid(x, y, z - 1);
      b.mask[FacePosY] = (y == int'(TopLevel)) || !is_solid(x, y + 1, z);
      b.mask[FaceNegY] = (y == 0) || !is_solid(x, y - 1, z);
      b.mask[FaceNegX] = (cx == CoordMin) || !is_solid(x - 1, y, z);
      b.mask[FacePosX] = (cx == CoordMax) || !is_solid(x + 1, y, z);
      b.top = (y + 1 == top);
      pending_faces = {pending_faces, b};
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR beat %0d: %s", beat_count, msg);
    error_count++;
  endtask

  // offer one beat after a random gap, predict it once accepted
  task automatic send_item(input logic k, input int x, input int z, input int h);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    column_x <= CoordW'(x);
    column_z <= CoordW'(z);
    height   <= HeightW'(h);
    do @(posedge clk); while (in_stall);
    predict_faces(k, CoordW'(x), CoordW'(z), HeightW'(h));
  endtask

  // receiver stall: random idling plus the long hold-off
  always @(posedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
  end

  // long hold-off, counted here so the sender keeps offering meanwhile
  initial begin : receiver_hold
    forever begin
      @(hold_start);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_off <= 1'b0;
    end
  end

  // compare each accepted result beat with the oldest predicted one
  always @(posedge clk) begin
    face_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_faces.size() == 0) begin
        report_mismatch($sformatf("unexpected beat x=%0d z=%0d level=%0d",
                                  out_x, out_z, level));
      end else begin
        want = pending_faces.pop_front();
        if (out_x !== want.x)
          report_mismatch($sformatf("out_x got %0d want %0d", out_x, want.x));
        if (out_z !== want.z)
          report_mismatch($sformatf("out_z got %0d want %0d", out_z, want.z));
        if (level !== want.lvl)
          report_mismatch($sformatf("level got %0d want %0d", level, want.lvl));
        if (face_mask !== want.mask)
          report_mismatch($sformatf("face_mask got %b want %b", face_mask, want.mask));
        if (last !== want.top)
          report_mismatch($sformatf("last got %b want %b", last, want.top));
      end
      beat_count++;
    end
  end

  // run limit
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  // scans of columns that were never loaded give nothing
  task automatic test_empty_scan();
    send_item(KindScan, 0, 0, 0);
    send_item(KindScan, 15, 15, 31);
  endtask

  // zero height stored as one, tall heights saturate at sixteen
  task automatic test_height_clamp();
    send_item(KindLoad, 5, 5, 0);
    send_item(KindScan, 5, 5, 0);
    send_item(KindLoad, 5, 5, 31);
    send_item(KindScan, 5, 5, 16);
    send_item(KindLoad, 5, 5, 17);
    send_item(KindScan, 5, 5, 1);
  endtask

  // chunk corners expose their edge faces
  task automatic test_chunk_corners();
    send_item(KindLoad, 0, 0, 16);
    send_item(KindLoad, 15, 15, 16);
    send_item(KindLoad, 0, 15, 3);
    send_item(KindLoad, 15, 0, 9);
    send_item(KindScan, 0, 0, 0);
    send_item(KindScan, 15, 15, 0);
    send_item(KindScan, 0, 15, 0);
    send_item(KindScan, 15, 0, 0);
  endtask

  // column surrounded by neighbours of mixed heights
  task automatic test_buried_column();
    send_item(KindLoad, 7, 7, 8);
    send_item(KindLoad, 6, 7, 4);
    send_item(KindLoad, 8, 7, 16);
    send_item(KindLoad, 7, 6, 8);
    send_item(KindLoad, 7, 8, 12);
    send_item(KindScan, 7, 7, 0);
    send_item(KindScan, 8, 7, 0);
  endtask

  // receiver holds off while tall scans keep coming, so the input stalls
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_item(KindLoad, 3, 3, 16);
    send_item(KindLoad, 3, 4, 10);
    -> hold_start;
    repeat (6) begin
      send_item(KindScan, 3, 3, 0);
      send_item(KindScan, 3, 4, 0);
    end
  endtask

  // random beats, mostly clustered so neighbours are loaded
  task automatic test_random_phase(input int n, input int send_pct, input int recv_pct);
    int   x;
    int   z;
    int   h;
    int   roll;
    logic k;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 80) begin
        x = $urandom_range(12) + $urandom_range(3);
        z = $urandom_range(12) + $urandom_range(3);
      end else begin
        x = $urandom_range(15);
        z = $urandom_range(15);
      end
      k = ($urandom_range(1) == 0) ? KindLoad : KindScan;
      roll = $urandom_range(99);
      if (roll < 80) h = $urandom_range(16, 1);
      else if (roll < 90) h = 0;
      else h = $urandom_range(31, 17);
      send_item(k, x, z, h);
    end
  endtask

  initial begin : main
    for (int i = 0; i < GRID*GRID; i++) model_heights[i] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_scan();
    test_height_clamp();
    test_chunk_corners();
    test_buried_column();
    test_random_phase(150, 32, 52);
    test_random_phase(150, 52, 32);
    test_backpressure();
    test_random_phase(100, 0, 0);

    // drain
    in_valid <= 1'b0;
    while (pending_faces.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/vcfc_pkg.sv
rtl/core/vcfc_height_mem.sv
rtl/core/vcfc_scan_ctrl.sv
rtl/core/voxel_column_face_cull.sv
bench/tb_voxel_column_face_cull.sv
